// File: rtl/mbfu_pkg.sv
`default_nettype none

package mbfu_pkg;

  localparam int DefStoreBits    = 32;
  localparam int DefMaxFieldBits = 32;

  // command queue between the front and the back part
  localparam int QueueDepth = 4;

  localparam int ByteBits  = 8;
  localparam int WidthBits = 6;
  localparam int ChunkBits = 4;

  typedef enum logic [1:0] {
    StChunk  = 2'd0,
    StAccept = 2'd1,
    StFull   = 2'd2,
    StShort  = 2'd3
  } status_e;

  typedef enum logic {
    ActPush    = 1'b0,
    ActExtract = 1'b1
  } action_e;

  // control part of one queued command, the field value travels beside it
  typedef struct packed {
    status_e              status;
    logic [WidthBits-1:0] width;
  } cmd_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mbfu_front.sv
`default_nettype none

module mbfu_front #(
  parameter int STORE_BITS     = mbfu_pkg::DefStoreBits,
  parameter int MAX_FIELD_BITS = mbfu_pkg::DefMaxFieldBits
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           action_i,
  input  wire logic [mbfu_pkg::ByteBits-1:0]  data_byte_i,
  input  wire logic [mbfu_pkg::WidthBits-1:0] field_width_i,
  input  wire logic                           q_full_i,
  output logic                                q_write_o,
  output mbfu_pkg::cmd_ctrl_t                 q_ctrl_o,
  output logic [MAX_FIELD_BITS-1:0]           q_value_o
);
  import mbfu_pkg::*;

  localparam int CntW = $clog2(STORE_BITS + 1);
  localparam int CmpW = (CntW > 7) ? CntW : 7;
  localparam int SW   = (STORE_BITS > MAX_FIELD_BITS) ? STORE_BITS : MAX_FIELD_BITS;

  logic [STORE_BITS-1:0] store_q, store_d;
  logic [CntW-1:0]       cnt_q, cnt_d;

  logic                  accept;
  logic                  full;
  logic                  too_big;
  logic                  short_bits;
  logic [CmpW-1:0]       cnt_ext;
  logic [CmpW-1:0]       width_ext;
  logic [CmpW-1:0]       rest;
  logic [SW-1:0]         shifted;
  logic [MAX_FIELD_BITS-1:0] field_mask;

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;
  assign q_write_o  = accept;

  assign full       = cnt_q > CntW'(STORE_BITS - ByteBits);
  assign cnt_ext    = CmpW'(cnt_q);
  assign width_ext  = CmpW'(field_width_i);
  assign too_big    = width_ext > CmpW'(MAX_FIELD_BITS);
  assign short_bits = too_big || (width_ext > cnt_ext);
  assign rest       = cnt_ext - width_ext;

  // oldest bits sit highest, so the field is what lies above the remaining bits
  assign shifted    = SW'(store_q) >> rest;
  assign field_mask = ~({MAX_FIELD_BITS{1'b1}} << field_width_i);

  always_comb begin
    store_d   = store_q;
    cnt_d     = cnt_q;
    q_ctrl_o  = '{status: StChunk, width: '0};
    q_value_o = '0;
    if (action_i == ActPush) begin
      if (full) begin
        q_ctrl_o.status = StFull;
      end else begin
        q_ctrl_o.status = StAccept;
        store_d = {store_q[STORE_BITS-ByteBits-1:0], data_byte_i};
        cnt_d   = cnt_q + CntW'(ByteBits);
      end
    end else if (field_width_i == '0) begin
      q_ctrl_o.status = StChunk;
    end else if (short_bits) begin
      q_ctrl_o.status = StShort;
    end else begin
      q_ctrl_o.width = field_width_i;
      q_value_o      = shifted[MAX_FIELD_BITS-1:0] & field_mask;
      cnt_d          = CntW'(rest);
      store_d        = store_q & ~({STORE_BITS{1'b1}} << rest);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      store_q <= store_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mbfu_queue.sv
`default_nettype none

module mbfu_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = mbfu_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              write_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic                   full_o,
  input  wire logic              read_i,
  output logic                   empty_o,
  output logic [DATA_W-1:0]      rdata_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = cnt_q == CntW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (write_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (write_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (read_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (write_i && !read_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (read_i && !write_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mbfu_back.sv
`default_nettype none

module mbfu_back #(
  parameter int MAX_FIELD_BITS = mbfu_pkg::DefMaxFieldBits
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            q_empty_i,
  input  wire mbfu_pkg::cmd_ctrl_t             q_ctrl_i,
  input  wire logic [MAX_FIELD_BITS-1:0]       q_value_i,
  output logic                                 q_read_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [mbfu_pkg::ByteBits-1:0]        chunk_o,
  output logic [mbfu_pkg::ChunkBits-1:0]       chunk_bits_o,
  output mbfu_pkg::status_e                    status_o,
  output logic                                 last_o
);
  import mbfu_pkg::*;

  localparam int NBytes = (MAX_FIELD_BITS + ByteBits - 1) / ByteBits;

  logic                      busy_q;
  cmd_ctrl_t                 work_ctrl_q;
  logic [MAX_FIELD_BITS-1:0] work_val_q;

  logic                      out_valid_q;
  logic [ByteBits-1:0]       chunk_q;
  logic [ChunkBits-1:0]      bits_q;
  status_e                   status_q;
  logic                      last_q;

  logic                      advance;
  logic                      have;
  cmd_ctrl_t                 src_ctrl;
  logic [MAX_FIELD_BITS-1:0] src_val;
  logic [NBytes*ByteBits-1:0] src_pad;
  logic [ChunkBits-1:0]      n_bits;
  logic [WidthBits-1:0]      rem_next;
  logic [WidthBits-1:0]      byte_idx;
  logic [ByteBits-1:0]       chunk_sel;
  logic                      is_last;

  assign advance  = !out_valid_q || out_ready_i;
  assign have     = busy_q || !q_empty_i;
  assign q_read_o = advance && !busy_q && !q_empty_i;

  assign src_ctrl = busy_q ? work_ctrl_q : q_ctrl_i;
  assign src_val  = busy_q ? work_val_q : q_value_i;
  assign src_pad  = (NBytes * ByteBits)'(src_val);

  // leading partial chunk first, whole bytes after it
  always_comb begin
    if (src_ctrl.width == '0) begin
      n_bits = '0;
    end else if (src_ctrl.width[2:0] != 3'd0) begin
      n_bits = ChunkBits'(src_ctrl.width[2:0]);
    end else begin
      n_bits = ChunkBits'(ByteBits);
    end
  end

  assign rem_next = src_ctrl.width - WidthBits'(n_bits);
  assign byte_idx = rem_next >> 3;
  assign is_last  = rem_next == '0;

  always_comb begin
    chunk_sel = '0;
    for (int i = 0; i < NBytes; i++) begin
      if (byte_idx == WidthBits'(i)) begin
        chunk_sel = chunk_sel | src_pad[i*ByteBits +: ByteBits];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= have;
      if (have) begin
        busy_q <= !is_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && have) begin
      work_ctrl_q.status <= src_ctrl.status;
      work_ctrl_q.width  <= rem_next;
      work_val_q         <= src_val;
      chunk_q            <= chunk_sel;
      bits_q             <= n_bits;
      status_q           <= src_ctrl.status;
      last_q             <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign chunk_o      = chunk_q;
  assign chunk_bits_o = bits_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_field_unpacker.sv
// channel  | direction | tdata (lsb up)                        | tuser   | tlast
// s_axis   | in        | data_byte[7:0], field_width[13:8], pad | action  | -
// m_axis   | out       | chunk[7:0], chunk_bits[11:8], pad      | status  | last
//
// the bit buffer is updated in the same cycle that a transfer is taken on s_axis
// results leave the back part one per cycle while m_axis is ready: one for a push or a status result,
// ceil(width/8) chunks for an extract
// a four-entry command queue separates the two parts; s_axis stalls only when it is full
// reset clears the bit buffer, the queue and the output register, no startup pass
`default_nettype none

module msb_first_bit_field_unpacker #(
  parameter int STORE_BITS     = mbfu_pkg::DefStoreBits,
  parameter int MAX_FIELD_BITS = mbfu_pkg::DefMaxFieldBits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // data_byte[7:0], field_width[13:8]
  input  wire logic        s_axis_tuser_i,  // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // chunk[7:0], chunk_bits[11:8]
  output logic [1:0]       m_axis_tuser_o,  // status
  output logic             m_axis_tlast_o
);
  import mbfu_pkg::*;

  localparam int QDataW = $bits(cmd_ctrl_t) + MAX_FIELD_BITS;

  logic                      q_full;
  logic                      q_empty;
  logic                      q_write;
  logic                      q_read;
  cmd_ctrl_t                 wr_ctrl;
  logic [MAX_FIELD_BITS-1:0] wr_value;
  logic [QDataW-1:0]         q_rdata;
  cmd_ctrl_t                 rd_ctrl;
  logic [MAX_FIELD_BITS-1:0] rd_value;

  logic [ByteBits-1:0]       chunk;
  logic [ChunkBits-1:0]      chunk_bits;
  status_e                   status;

  mbfu_front #(
    .STORE_BITS    (STORE_BITS),
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .action_i     (s_axis_tuser_i),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .field_width_i(s_axis_tdata_i[13:8]),
    .q_full_i     (q_full),
    .q_write_o    (q_write),
    .q_ctrl_o     (wr_ctrl),
    .q_value_o    (wr_value)
  );

  mbfu_queue #(
    .DATA_W(QDataW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .write_i(q_write),
    .wdata_i({wr_ctrl, wr_value}),
    .full_o (q_full),
    .read_i (q_read),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  assign rd_ctrl  = cmd_ctrl_t'(q_rdata[QDataW-1:MAX_FIELD_BITS]);
  assign rd_value = q_rdata[MAX_FIELD_BITS-1:0];

  mbfu_back #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_ctrl_i    (rd_ctrl),
    .q_value_i   (rd_value),
    .q_read_o    (q_read),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .chunk_o     (chunk),
    .chunk_bits_o(chunk_bits),
    .status_o    (status),
    .last_o      (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, chunk_bits, chunk};
  assign m_axis_tuser_o = status;

endmodule

`default_nettype wire

// File: tb/msb_first_bit_field_unpacker_tb.sv
`default_nettype none

module msb_first_bit_field_unpacker_tb;
  import mbfu_pkg::*;

  localparam int StoreBits    = 32;
  localparam int MaxFieldBits = 32;
  localparam int RandomItems  = 310;
  localparam int CycleLimit   = 300000;
  localparam int HoldCycles   = 400;

  typedef struct packed {
    action_e     act;
    logic [7:0]  data_b;
    logic [5:0]  width;
    logic        drain;
  } item_t;

  typedef struct packed {
    logic [7:0] chunk;
    logic [3:0] nbits;
    status_e    status;
    logic       last;
  } result_t;

  typedef enum logic [1:0] {
    RxOpen,
    RxCoin,
    RxSparse,
    RxToggle
  } rx_mode_e;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  item_t       pending[$];
  result_t     expected_results[$];

  // bit buffer as the block should hold it
  logic [31:0] buf_bits;
  int unsigned buf_count;
  // bit count tracked while building the stimulus
  int unsigned gen_bits;

  bit          in_fire;
  int          cycles;
  int          taken;
  int          errors;
  int          n_push, n_full, n_short, n_zero, n_chunk;

  int          gap_left;
  int          burst_left;
  rx_mode_e    rx_mode;
  int          rx_left;
  int          hold_left;
  bit          hold_done;

  msb_first_bit_field_unpacker u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),  // data_byte[7:0], field_width[13:8]
    .s_axis_tuser_i  (s_tuser),  // action
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),  // chunk[7:0], chunk_bits[11:8]
    .m_axis_tuser_o  (m_tuser),  // status
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic queue_result(input logic [7:0] chunk, input logic [3:0] nbits,
                              input status_e status, input logic last);
    expected_results.push_back('{chunk: chunk, nbits: nbits, status: status, last: last});
  endtask

  task automatic unpack_step(input action_e act, input logic [7:0] db, input logic [5:0] w);
    logic [63:0] wide;
    int unsigned rem;
    int unsigned n;
    if (act == ActPush) begin
      if (buf_count > StoreBits - 8) begin
        queue_result(8'h00, 4'd0, StFull, 1'b1);
        n_full++;
      end else begin
        buf_bits  = {buf_bits[23:0], db};
        buf_count = buf_count + 8;
        queue_result(8'h00, 4'd0, StAccept, 1'b1);
        n_push++;
      end
    end else if (w == 6'd0) begin
      queue_result(8'h00, 4'd0, StChunk, 1'b1);
      n_zero++;
    end else if (w > MaxFieldBits || w > buf_count) begin
      queue_result(8'h00, 4'd0, StShort, 1'b1);
      n_short++;
    end else begin
      rem = w;
      while (rem > 0) begin
        // leading partial chunk first, whole bytes after it
        n    = (rem % 8 != 0) ? rem % 8 : 8;
        wide = {32'd0, buf_bits} >> (buf_count - n);
        buf_count = buf_count - n;
        buf_bits  = buf_bits & 32'(((64'd1 << buf_count) - 64'd1));
        rem  = rem - n;
        queue_result(wide[7:0] & 8'((16'd1 << n) - 16'd1), 4'(n), StChunk, rem == 0);
        n_chunk++;
      end
    end
  endtask

  task automatic add_item(input action_e act, input logic [7:0] db, input logic [5:0] w,
                          input logic drain);
    pending.push_back('{act: act, data_b: db, width: w, drain: drain});
    if (act == ActPush) begin
      if (gen_bits <= StoreBits - 8) gen_bits = gen_bits + 8;
    end else if (w != 0 && w <= MaxFieldBits && w <= gen_bits) begin
      gen_bits = gen_bits - w;
    end
  endtask

  // sender: bursts of random length with random gaps between them
  always @(negedge clk) begin
    item_t nxt;
    logic  give;
    give = s_valid && !in_fire;
    if (!rst_n) begin
      give = 1'b0;
    end else if (!give) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0 &&
                   !(pending[0].drain && expected_results.size() > 0)) begin
        nxt = pending.pop_front();
        s_tdata <= {2'b00, nxt.width, nxt.data_b};
        s_tuser <= nxt.act;
        give = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end
      end
    end
    s_valid <= give;
  end

  // receiver: changing stall pattern plus one long hold-off
  always @(negedge clk) begin
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RxOpen:   rdy = 1'b1;
      RxCoin:   rdy = 1'($urandom_range(0, 1));
      RxSparse: rdy = ($urandom_range(0, 3) == 0);
      default:  rdy = ~m_ready;
    endcase
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && taken >= 120) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      rdy = 1'b0;
    end
    m_ready <= rdy;
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t timeout, %0d results still outstanding", $time, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_fire = rst_n && s_valid && s_ready;
      if (in_fire) begin
        unpack_step(action_e'(s_tuser), s_tdata[7:0], s_tdata[13:8]);
        taken++;
      end
      if (rst_n && m_valid && m_ready) begin
        got = '{chunk: m_tdata[7:0], nbits: m_tdata[11:8], status: status_e'(m_tuser),
                last: m_tlast};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t unexpected transfer: expected none, got %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.chunk !== want.chunk) begin
            errors++;
            $display("%0t chunk: expected %h, got %h", $time, want.chunk, got.chunk);
          end
          if (got.nbits !== want.nbits) begin
            errors++;
            $display("%0t chunk_bits: expected %0d, got %0d", $time, want.nbits, got.nbits);
          end
          if (got.status !== want.status) begin
            errors++;
            $display("%0t status: expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.last !== want.last) begin
            errors++;
            $display("%0t last: expected %b, got %b", $time, want.last, got.last);
          end
        end
      end
    end
  end

  initial begin
    int unsigned roll;
    int unsigned top;
    buf_bits  = '0;
    buf_count = 0;
    gen_bits  = 0;

    // empty buffer, zero width, fill to the top, overflow, full-width read, oversize request
    add_item(ActExtract, 8'hFF, 6'd1,   1'b0);
    add_item(ActExtract, 8'h00, 6'd0,   1'b0);
    add_item(ActPush,    8'hFF, 6'h3F,  1'b0);
    add_item(ActPush,    8'h00, 6'd0,   1'b0);
    add_item(ActPush,    8'hA5, 6'd21,  1'b0);
    add_item(ActPush,    8'h5A, 6'd42,  1'b0);
    add_item(ActPush,    8'h77, 6'd0,   1'b0);
    add_item(ActExtract, 8'hFF, 6'd32,  1'b0);
    add_item(ActExtract, 8'h00, 6'd63,  1'b0);
    // single-bit and partial fields
    add_item(ActPush,    8'h80, 6'd0,   1'b0);
    add_item(ActExtract, 8'h00, 6'd1,   1'b0);
    add_item(ActExtract, 8'hFF, 6'd7,   1'b0);
    add_item(ActPush,    8'hC3, 6'd0,   1'b0);
    add_item(ActPush,    8'h3C, 6'd0,   1'b0);
    add_item(ActPush,    8'h0F, 6'd0,   1'b0);
    add_item(ActExtract, 8'h00, 6'd13,  1'b0);
    add_item(ActPush,    8'h99, 6'd0,   1'b0);
    add_item(ActPush,    8'h66, 6'd0,   1'b0);
    add_item(ActPush,    8'h12, 6'd0,   1'b0);
    // width above the maximum, one more than held, then exactly what is held
    add_item(ActExtract, 8'h00, 6'd33,  1'b0);
    add_item(ActExtract, 8'h00, 6'd28,  1'b0);
    add_item(ActExtract, 8'h00, 6'd27,  1'b0);
    add_item(ActPush,    8'h01, 6'd0,   1'b1);

    for (int i = 0; i < RandomItems; i++) begin
      roll = $urandom_range(0, 99);
      top  = (gen_bits < MaxFieldBits) ? gen_bits : MaxFieldBits;
      if (roll < 12) begin
        // noise: any action, any width, including short and oversize requests
        add_item(action_e'($urandom_range(0, 1)), 8'($urandom), 6'($urandom_range(0, 63)),
                 i == 150);
      end else if (gen_bits < 8 || (gen_bits <= StoreBits - 8 && $urandom_range(0, 1) == 1)) begin
        add_item(ActPush, 8'($urandom), 6'($urandom_range(0, 63)), i == 150);
      end else if ($urandom_range(0, 2) == 0 && top >= 8) begin
        add_item(ActExtract, 8'($urandom), 6'(8 * $urandom_range(1, top / 8)), i == 150);
      end else begin
        add_item(ActExtract, 8'($urandom), 6'($urandom_range(1, top)), i == 150);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending.size() != 0 || s_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d transfers in: %0d bytes taken, %0d dropped on full buffer",
             taken, n_push, n_full);
    $display("%0d field chunks, %0d short requests, %0d zero-width requests",
             n_chunk, n_short, n_zero);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/mbfu_pkg.sv
rtl/mbfu_front.sv
rtl/mbfu_queue.sv
rtl/mbfu_back.sv
rtl/msb_first_bit_field_unpacker.sv
tb/msb_first_bit_field_unpacker_tb.sv
